// ===== rtl/stack_machine_alu_macros.svh =====
// assertion macros for the stack machine alu
`ifndef STACK_MACHINE_ALU_MACROS_SVH
`define STACK_MACHINE_ALU_MACROS_SVH

// same-cycle implication, held off while in reset
`define SMALU_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("stack machine alu: same-cycle check failed");

// next-cycle implication, held off while in reset
`define SMALU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("stack machine alu: next-cycle check failed");

`endif

// ===== rtl/smalu_pkg.sv =====
// package: field widths, command and status codes, controller types
`timescale 1ns / 1ps
`default_nettype none
package smalu_pkg;

  localparam int CMD_WIDTH       = 3;
  localparam int OPERAND_WIDTH   = 32;
  localparam int VALUE_WIDTH     = 32;
  localparam int STATUS_WIDTH    = 3;
  localparam int DEPTH_WIDTH     = 9;
  localparam int DEF_STACK_DEPTH = 256;
  localparam int DEF_DATA_WIDTH  = 32;

  typedef logic [CMD_WIDTH-1:0] cmd_t;

  localparam cmd_t CMD_PUSH = 3'd0;
  localparam cmd_t CMD_ADD  = 3'd1;
  localparam cmd_t CMD_POP  = 3'd2;
  localparam cmd_t CMD_MUL  = 3'd3;
  localparam cmd_t CMD_DIV  = 3'd4;
  localparam cmd_t CMD_HALT = 3'd5;

  typedef enum logic [STATUS_WIDTH-1:0] {
    ST_OK      = 3'd0,
    ST_HALTED  = 3'd1,
    ST_UNDER   = 3'd2,
    ST_OVER    = 3'd3,
    ST_DIVZERO = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_ITER,
    S_FINISH
  } ctrl_state_t;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic start;
    logic commit;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic need_iter;
    logic iter_busy;
    logic out_free;
  } dp_stat_t;

endpackage
`default_nettype wire

// ===== rtl/smalu_intf.sv =====
// valid/ready channel interfaces for instructions and results
`timescale 1ns / 1ps
`default_nettype none
interface smalu_in_if;
  import smalu_pkg::*;

  logic                            valid;
  logic                            ready;
  logic [CMD_WIDTH-1:0]            cmd;
  logic signed [OPERAND_WIDTH-1:0] operand;

  modport source (output valid, output cmd, output operand, input ready);
  modport sink (input valid, input cmd, input operand, output ready);
endinterface

interface smalu_out_if;
  import smalu_pkg::*;

  logic                          valid;
  logic                          ready;
  logic signed [VALUE_WIDTH-1:0] value;
  logic [STATUS_WIDTH-1:0]       status;
  logic [DEPTH_WIDTH-1:0]        depth;

  modport source (output valid, output value, output status, output depth, input ready);
  modport sink (input valid, input value, input status, input depth, output ready);
endinterface
`default_nettype wire

// ===== rtl/stack_machine_alu.sv =====
// stack machine alu: one instruction transaction in, one result transaction out
// push, pop, add, halt, no-op and any error go from capture through execute to finish, where the
//   result commits once the output register is free; multiply and divide also wait in the
//   iterate state on the shared bit-serial multiply/divide unit that retires one bit per cycle
// one instruction in flight: the controller returns to idle, ready for the next, as the result registers
// reset: synchronous active-low clears depth, halt flag, controller and result valid; stack
//   contents are not cleared, only entries below the depth are ever used
`timescale 1ns / 1ps
`default_nettype none
`include "stack_machine_alu_macros.svh"
module stack_machine_alu #(
  parameter int STACK_DEPTH = smalu_pkg::DEF_STACK_DEPTH,
  parameter int DATA_WIDTH  = smalu_pkg::DEF_DATA_WIDTH
) (
  input  logic        clk,
  input  logic        rst_n,
  smalu_in_if.sink    in_ch,
  smalu_out_if.source out_ch
);
  import smalu_pkg::*;

  // command and status bundles between controller and datapath
  ctrl_cmd_t ctrl_cmd;
  dp_stat_t  dp_stat;

  // controller: owns the input handshake and sequences each transaction
  smalu_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .stat     (dp_stat),
    .cmd      (ctrl_cmd)
  );

  // datapath: stack memory, alu, iterative unit and the result register,
  // which lets a finished result wait while the next instruction is taken
  smalu_dp #(
    .STACK_DEPTH (STACK_DEPTH),
    .DATA_WIDTH  (DATA_WIDTH)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (ctrl_cmd),
    .stat       (dp_stat),
    .in_cmd     (in_ch.cmd),
    .in_operand (in_ch.operand),
    .out_ready  (out_ch.ready),
    .out_valid  (out_ch.valid),
    .out_value  (out_ch.value),
    .out_status (out_ch.status),
    .out_depth  (out_ch.depth)
  );

  // one instruction at a time: no second acceptance straight after one
  `SMALU_ASSERT_NEXT(a_one_in_flight, clk, rst_n, in_ch.valid && in_ch.ready, !in_ch.ready)
  // a commit never overwrites a result still waiting on the output
  `SMALU_ASSERT_NOW(a_commit_slot_free, clk, rst_n, ctrl_cmd.commit, dp_stat.out_free)
  // the iterative unit is never restarted mid-operation
  `SMALU_ASSERT_NOW(a_start_idle_unit, clk, rst_n, ctrl_cmd.start, !dp_stat.iter_busy)
  // a new result only appears as the consequence of a commit
  `SMALU_ASSERT_NOW(a_valid_from_commit, clk, rst_n, $rose(out_ch.valid), $past(ctrl_cmd.commit))

endmodule
`default_nettype wire

// ===== rtl/smalu_iter.sv =====
// shared bit-serial unit: shift-add multiply and restoring signed divide
`timescale 1ns / 1ps
`default_nettype none
module smalu_iter #(
  parameter int DATA_WIDTH = smalu_pkg::DEF_DATA_WIDTH
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic                  is_div,
  input  logic [DATA_WIDTH-1:0] op_a,
  input  logic [DATA_WIDTH-1:0] op_b,
  output logic                  busy,
  output logic [DATA_WIDTH-1:0] result
);
  import smalu_pkg::*;

  localparam int CNTW = $clog2(DATA_WIDTH + 1);

  logic                  busy_r, busy_nxt;
  logic [CNTW-1:0]       cnt_r, cnt_nxt;
  logic                  div_r;
  logic                  neg_r;
  logic [DATA_WIDTH-1:0] acc_r, acc_nxt;
  logic [DATA_WIDTH-1:0] x_r, x_nxt;
  logic [DATA_WIDTH-1:0] y_r, y_nxt;
  logic [DATA_WIDTH-1:0] mag_a, mag_b;
  logic [DATA_WIDTH:0]   trial;
  logic                  ge;

  assign mag_a = op_a[DATA_WIDTH-1] ? (~op_a + 1'b1) : op_a;
  assign mag_b = op_b[DATA_WIDTH-1] ? (~op_b + 1'b1) : op_b;

  // restoring step: bring in next dividend bit, subtract when it fits
  assign trial = {acc_r, x_r[DATA_WIDTH-1]};
  assign ge    = trial >= {1'b0, y_r};

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    acc_nxt  = acc_r;
    x_nxt    = x_r;
    y_nxt    = y_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNTW'(DATA_WIDTH);
      acc_nxt  = '0;
      x_nxt    = is_div ? mag_a : op_a;
      y_nxt    = is_div ? mag_b : op_b;
    end else if (busy_r) begin
      cnt_nxt  = cnt_r - 1'b1;
      busy_nxt = cnt_r != CNTW'(1);
      if (div_r) begin
        acc_nxt = ge ? DATA_WIDTH'(trial - {1'b0, y_r}) : trial[DATA_WIDTH-1:0];
        x_nxt   = {x_r[DATA_WIDTH-2:0], ge};
      end else begin
        acc_nxt = acc_r + (x_r[0] ? y_r : '0);
        x_nxt   = x_r >> 1;
        y_nxt   = y_r << 1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    x_r   <= x_nxt;
    y_r   <= y_nxt;
    if (start) begin
      div_r <= is_div;
      neg_r <= op_a[DATA_WIDTH-1] ^ op_b[DATA_WIDTH-1];
    end
  end

  assign busy   = busy_r;
  assign result = div_r ? (neg_r ? (~x_r + 1'b1) : x_r) : acc_r;

endmodule
`default_nettype wire

// ===== rtl/smalu_ctrl.sv =====
// controller state machine: capture, execute, iterate, commit
`timescale 1ns / 1ps
`default_nettype none
module smalu_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  smalu_pkg::dp_stat_t   stat,
  output smalu_pkg::ctrl_cmd_t  cmd
);
  import smalu_pkg::*;

  ctrl_state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:   if (in_valid) state_nxt = S_EXEC;
      S_EXEC:   state_nxt = stat.need_iter ? S_ITER : S_FINISH;
      S_ITER:   if (!stat.iter_busy) state_nxt = S_FINISH;
      S_FINISH: if (stat.out_free) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready    = 1'b0;
    cmd.capture = 1'b0;
    cmd.start   = 1'b0;
    cmd.commit  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      S_EXEC:   cmd.start = stat.need_iter;
      S_ITER:   ;
      S_FINISH: cmd.commit = stat.out_free;
      default:  ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/smalu_dp.sv =====
// datapath: stack memory, depth and halt state, alu, result register
`timescale 1ns / 1ps
`default_nettype none
module smalu_dp #(
  parameter int STACK_DEPTH = smalu_pkg::DEF_STACK_DEPTH,
  parameter int DATA_WIDTH  = smalu_pkg::DEF_DATA_WIDTH
) (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  smalu_pkg::ctrl_cmd_t                      cmd,
  output smalu_pkg::dp_stat_t                       stat,
  input  logic [smalu_pkg::CMD_WIDTH-1:0]           in_cmd,
  input  logic signed [smalu_pkg::OPERAND_WIDTH-1:0] in_operand,
  input  logic                                      out_ready,
  output logic                                      out_valid,
  output logic [smalu_pkg::VALUE_WIDTH-1:0]         out_value,
  output logic [smalu_pkg::STATUS_WIDTH-1:0]        out_status,
  output logic [smalu_pkg::DEPTH_WIDTH-1:0]         out_depth
);
  import smalu_pkg::*;

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(STACK_DEPTH + 1);

  logic [DATA_WIDTH-1:0] mem [STACK_DEPTH];

  cmd_t                  cmd_r;
  logic [DATA_WIDTH-1:0] opnd_r;
  logic [CW-1:0]         count_r, count_nxt;
  logic                  halted_r, halted_nxt;
  logic [DATA_WIDTH-1:0] top_r, next_r;
  logic [AW-1:0]         top_idx, next_idx, wr_idx;
  logic                  wr_en;
  logic [DATA_WIDTH-1:0] wr_data;
  status_t               status;
  logic [DATA_WIDTH-1:0] res;
  logic [DATA_WIDTH-1:0] value;
  logic                  iter_busy;
  logic [DATA_WIDTH-1:0] iter_res;

  logic                   out_valid_r;
  logic [VALUE_WIDTH-1:0] out_value_r;
  status_t                out_status_r;
  logic [DEPTH_WIDTH-1:0] out_depth_r;

  assign top_idx  = AW'(count_r - CW'(1));
  assign next_idx = AW'(count_r - CW'(2));

  // operands re-read every cycle; address only moves on commit
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_idx] <= wr_data;
    top_r  <= mem[top_idx];
    next_r <= mem[next_idx];
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cmd_r  <= in_cmd;
      opnd_r <= DATA_WIDTH'(in_operand);
    end
  end

  // error classification
  always_comb begin
    status = ST_OK;
    if (halted_r) begin
      status = ST_HALTED;
    end else begin
      unique case (cmd_r) inside
        CMD_PUSH: if (count_r == CW'(STACK_DEPTH)) status = ST_OVER;
        CMD_POP:  if (count_r == '0) status = ST_UNDER;
        CMD_ADD, CMD_MUL, CMD_DIV: begin
          if (count_r < CW'(2)) status = ST_UNDER;
          else if (cmd_r == CMD_DIV && next_r == '0) status = ST_DIVZERO;
        end
        default:  status = ST_OK;
      endcase
    end
  end

  smalu_iter #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_iter (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (cmd.start),
    .is_div (cmd_r == CMD_DIV),
    .op_a   (top_r),
    .op_b   (next_r),
    .busy   (iter_busy),
    .result (iter_res)
  );

  always_comb begin
    res        = '0;
    value      = '0;
    count_nxt  = count_r;
    halted_nxt = halted_r;
    wr_en      = 1'b0;
    wr_idx     = next_idx;
    wr_data    = res;
    unique case (cmd_r) inside
      CMD_ADD:          res = top_r + next_r;
      CMD_MUL, CMD_DIV: res = iter_res;
      CMD_POP:          res = top_r;
      default:          res = '0;
    endcase
    wr_data = res;
    if (status == ST_OK) begin
      unique case (cmd_r) inside
        CMD_PUSH: begin
          wr_en     = cmd.commit;
          wr_idx    = count_r[AW-1:0];
          wr_data   = opnd_r;
          count_nxt = count_r + CW'(1);
        end
        CMD_POP: begin
          value     = res;
          count_nxt = count_r - CW'(1);
        end
        CMD_ADD, CMD_MUL, CMD_DIV: begin
          value     = res;
          wr_en     = cmd.commit;
          count_nxt = count_r - CW'(1);
        end
        CMD_HALT: halted_nxt = 1'b1;
        default:  ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      halted_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.commit) begin
        count_r     <= count_nxt;
        halted_r    <= halted_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_value_r  <= VALUE_WIDTH'(value);
      out_status_r <= status;
      out_depth_r  <= DEPTH_WIDTH'(count_nxt);
    end
  end

  assign stat.need_iter = (status == ST_OK) && (cmd_r == CMD_MUL || cmd_r == CMD_DIV);
  assign stat.iter_busy = iter_busy;
  assign stat.out_free  = !out_valid_r || out_ready;

  assign out_valid  = out_valid_r;
  assign out_value  = out_value_r;
  assign out_status = out_status_r;
  assign out_depth  = out_depth_r;

endmodule
`default_nettype wire
